### sv/box_filter_mip_downsampler_unit_defines.svh
// Assertion macros used by the checker of the downsampler.
`ifndef BOX_FILTER_MIP_DOWNSAMPLER_UNIT_DEFINES_SVH
`define BOX_FILTER_MIP_DOWNSAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BFMD_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfmd check failed: %m");

// Next-cycle implication.
`define BFMD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfmd check failed: %m");

`endif

### sv/bfmd_pkg.sv
package bfmd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LOG2_LIMIT = 12;
    localparam int CNT_W      = LOG2_LIMIT;
    localparam int WIDTH_FLOOR_LOG2 = $clog2(MAX_WIDTH + 1) - 1;
    localparam int WL_MAX     = (WIDTH_FLOOR_LOG2 < LOG2_LIMIT) ? WIDTH_FLOOR_LOG2 : LOG2_LIMIT;

    localparam int LOG2_W     = 4;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int COMP_W     = 8;
    localparam int LANES      = 4;
    localparam int SUM_W      = COMP_W + 1;
    localparam int BOX_W      = COMP_W + 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_WIDTH_LOG2  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_HEIGHT_LOG2 = cfg_idx_t'(1);
    localparam cfg_idx_t REG_COMP_COUNT  = cfg_idx_t'(2);

    localparam logic [COUNT_W-1:0] COMP_COUNT_RESET = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] COMP_COUNT_MIN   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COMP_COUNT_MAX   = COUNT_W'(LANES);

    typedef logic [COMP_W-1:0]            comp_t;
    typedef logic [LANES-1:0][COMP_W-1:0] pixel_t;
    typedef logic [LANES-1:0][SUM_W-1:0]  sums_t;
    typedef logic [SLOT_W-1:0]            slot_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROW_WRITE,
        OP_COPY,
        OP_PAIR,
        OP_BOX
    } op_t;

    typedef struct packed {
        pixel_t pix;
        op_t    op;
        slot_t  slot;
        logic   last;
    } front_t;

    typedef struct packed {
        logic  we;
        logic  re;
        slot_t addr;
        sums_t wdata;
    } lb_req_t;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        r = n;
        if (n < COMP_COUNT_MIN)
        begin
            r = COMP_COUNT_MIN;
        end
        else if (n > COMP_COUNT_MAX)
        begin
            r = COMP_COUNT_MAX;
        end
        return r;
    endfunction

endpackage

### sv/box_filter_mip_downsampler_unit.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// in       | in_valid / in_ready   | in_c0..in_c3, one source pixel
// out      | out_valid / out_ready | out_c0..out_c3, last_pixel
// cfg      | cfg_wr_en             | cfg_index, cfg_wr_data
//
// One pixel per clock unless the output stalls; results pass the s1, s2 and output registers.
// The line buffer has one write port and one registered read port, used in different rows.
// Reset clears counters, config, valid flags, pair hold; not the data registers or line buffer.
// A stalled output stops the pipe; the output register and two stages buffer requests.
module box_filter_mip_downsampler_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  bfmd_pkg::cfg_idx_t              cfg_index,
    input  logic [bfmd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bfmd_pkg::comp_t                 in_c0,
    input  bfmd_pkg::comp_t                 in_c1,
    input  bfmd_pkg::comp_t                 in_c2,
    input  bfmd_pkg::comp_t                 in_c3,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bfmd_pkg::comp_t                 out_c0,
    output bfmd_pkg::comp_t                 out_c1,
    output bfmd_pkg::comp_t                 out_c2,
    output bfmd_pkg::comp_t                 out_c3,
    output logic                            last_pixel
);
    import bfmd_pkg::*;

    pixel_t             in_pix;
    pixel_t             out_pix;
    logic               s1_valid;
    logic               s1_ready;
    front_t             s1;
    logic [COUNT_W-1:0] comp_count;
    lb_req_t            lb_req;
    sums_t              lb_rdata;

    assign in_pix = {in_c3, in_c2, in_c1, in_c0};

    bfmd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_pix      (in_pix),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1          (s1),
        .comp_count  (comp_count)
    );

    bfmd_line_buf u_line_buf (
        .clk   (clk),
        .req   (lb_req),
        .rdata (lb_rdata)
    );

    bfmd_average u_average (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr_en),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1         (s1),
        .comp_count (comp_count),
        .lb_req     (lb_req),
        .lb_rdata   (lb_rdata),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pix    (out_pix),
        .last_pixel (last_pixel)
    );

    assign out_c0 = out_pix[0];
    assign out_c1 = out_pix[1];
    assign out_c2 = out_pix[2];
    assign out_c3 = out_pix[3];

endmodule

### sv/bfmd_front.sv
module bfmd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  bfmd_pkg::cfg_idx_t                  cfg_index,
    input  logic [bfmd_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bfmd_pkg::pixel_t                    in_pix,
    output logic                                s1_valid,
    input  logic                                s1_ready,
    output bfmd_pkg::front_t                    s1,
    output logic [bfmd_pkg::COUNT_W-1:0]        comp_count
);
    import bfmd_pkg::*;

    logic [LOG2_W-1:0]  width_log2_reg;
    logic [LOG2_W-1:0]  height_log2_reg;
    logic [COUNT_W-1:0] comp_count_reg;
    logic [CNT_W-1:0]   col_reg;
    logic [CNT_W-1:0]   row_reg;
    logic [CNT_W-1:0]   col_next;
    logic [CNT_W-1:0]   row_next;
    logic               s1_valid_reg;
    front_t             s1_reg;
    front_t             s1_next;

    logic [LOG2_W-1:0]  wl;
    logic [LOG2_W-1:0]  hl;
    logic [CNT_W-1:0]   xmask;
    logic [CNT_W-1:0]   ymask;
    logic [CNT_W-1:0]   x;
    logic [CNT_W-1:0]   y;
    logic               x_end;
    logic               y_end;
    logic               accept;

    always_comb
    begin
        wl = (width_log2_reg > LOG2_W'(WL_MAX)) ? LOG2_W'(WL_MAX) : width_log2_reg;
        hl = (height_log2_reg > LOG2_W'(LOG2_LIMIT)) ? LOG2_W'(LOG2_LIMIT) : height_log2_reg;
        xmask = ~({CNT_W{1'b1}} << wl);
        ymask = ~({CNT_W{1'b1}} << hl);
        x = col_reg & xmask;
        y = row_reg & ymask;
        x_end = (x == xmask);
        y_end = (y == ymask);

        s1_next.pix  = in_pix;
        s1_next.slot = SLOT_W'(x >> 1);
        s1_next.last = x_end && y_end;
        if ((wl == '0) && (hl == '0))
        begin
            s1_next.op = OP_COPY;
        end
        else if ((wl == '0) || (hl == '0))
        begin
            s1_next.op = (x[0] ^ y[0]) ? OP_PAIR : OP_HOLD;
        end
        else if (!x[0])
        begin
            s1_next.op = OP_HOLD;
        end
        else if (!y[0])
        begin
            s1_next.op = OP_ROW_WRITE;
        end
        else
        begin
            s1_next.op = OP_BOX;
        end

        if (x_end)
        begin
            col_next = '0;
            row_next = y_end ? '0 : y + CNT_W'(1);
        end
        else
        begin
            col_next = x + CNT_W'(1);
            row_next = y;
        end
    end

    assign in_ready   = !s1_valid_reg || s1_ready;
    assign accept     = in_valid && in_ready;
    assign s1_valid   = s1_valid_reg;
    assign s1         = s1_reg;
    assign comp_count = clamp_count(comp_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_log2_reg  <= '0;
            height_log2_reg <= '0;
            comp_count_reg  <= COMP_COUNT_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_WIDTH_LOG2:  width_log2_reg  <= cfg_wr_data[LOG2_W-1:0];
                    REG_HEIGHT_LOG2: height_log2_reg <= cfg_wr_data[LOG2_W-1:0];
                    REG_COMP_COUNT:  comp_count_reg  <= cfg_wr_data[COUNT_W-1:0];
                    default:         ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

### sv/bfmd_line_buf.sv
module bfmd_line_buf (
    input  logic              clk,
    input  bfmd_pkg::lb_req_t req,
    output bfmd_pkg::sums_t   rdata
);
    import bfmd_pkg::*;

    sums_t mem [LINE_DEPTH];
    sums_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bfmd_average.sv
module bfmd_average (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic                          s1_valid,
    output logic                          s1_ready,
    input  bfmd_pkg::front_t              s1,
    input  logic [bfmd_pkg::COUNT_W-1:0]  comp_count,
    output bfmd_pkg::lb_req_t             lb_req,
    input  bfmd_pkg::sums_t               lb_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bfmd_pkg::pixel_t              out_pix,
    output logic                          last_pixel
);
    import bfmd_pkg::*;

    pixel_t pair_hold_reg;
    logic   s2_valid_reg;
    pixel_t s2_pix_reg;
    pixel_t s2_hold_reg;
    op_t    s2_op_reg;
    logic   s2_last_reg;
    logic   out_valid_reg;
    pixel_t out_pix_reg;
    pixel_t out_pix_next;
    logic   last_reg;

    logic   out_free;
    logic   s1_adv;
    logic   s1_emit;
    logic   s2_move;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_ready = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid && s1_ready;
    assign s1_emit  = (s1.op == OP_COPY) || (s1.op == OP_PAIR) || (s1.op == OP_BOX);
    assign s2_move  = s2_valid_reg && out_free;

    always_comb
    begin
        lb_req.we   = s1_adv && (s1.op == OP_ROW_WRITE);
        lb_req.re   = s1_adv && (s1.op == OP_BOX);
        lb_req.addr = s1.slot;
        for (int i = 0; i < LANES; i++)
        begin
            lb_req.wdata[i] = SUM_W'(pair_hold_reg[i]) + SUM_W'(s1.pix[i]);
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] pair_sum;
        logic [BOX_W-1:0] box_sum;
        for (int i = 0; i < LANES; i++)
        begin
            pair_sum = SUM_W'(s2_hold_reg[i]) + SUM_W'(s2_pix_reg[i]) + SUM_W'(1);
            box_sum  = BOX_W'(lb_rdata[i]) + BOX_W'(s2_hold_reg[i])
                     + BOX_W'(s2_pix_reg[i]) + BOX_W'(2);
            unique case (s2_op_reg)
                OP_COPY: out_pix_next[i] = s2_pix_reg[i];
                OP_PAIR: out_pix_next[i] = pair_sum[SUM_W-1:1];
                OP_BOX:  out_pix_next[i] = box_sum[BOX_W-1:2];
                default: out_pix_next[i] = '0;
            endcase
            if (COUNT_W'(i) >= comp_count)
            begin
                out_pix_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_hold_reg <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                pair_hold_reg <= '0;
            end
            else if (s1_adv && (s1.op == OP_HOLD))
            begin
                pair_hold_reg <= s1.pix;
            end

            if (s1_adv && s1_emit)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit)
        begin
            s2_pix_reg  <= s1.pix;
            s2_hold_reg <= pair_hold_reg;
            s2_op_reg   <= s1.op;
            s2_last_reg <= s1.last;
        end
        if (s2_move)
        begin
            out_pix_reg <= out_pix_next;
            last_reg    <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pix    = out_pix_reg;
    assign last_pixel = last_reg;

endmodule

### sv/bfmd_checker.sv
`include "box_filter_mip_downsampler_unit_defines.svh"

module bfmd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_wr_en,
    input bfmd_pkg::cfg_idx_t              cfg_index,
    input logic [bfmd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input logic                            in_valid,
    input logic                            in_ready,
    input bfmd_pkg::comp_t                 in_c0,
    input bfmd_pkg::comp_t                 in_c1,
    input bfmd_pkg::comp_t                 in_c2,
    input bfmd_pkg::comp_t                 in_c3,
    input logic                            out_valid,
    input logic                            out_ready,
    input bfmd_pkg::comp_t                 out_c0,
    input bfmd_pkg::comp_t                 out_c1,
    input bfmd_pkg::comp_t                 out_c2,
    input bfmd_pkg::comp_t                 out_c3,
    input logic                            last_pixel
);
    import bfmd_pkg::*;

    logic               seen_in_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_eff;
    logic               unused_zero;
    logic               in_seen;

    assign in_seen   = (in_c0 == in_c0) && (in_c1 == in_c1) && (in_c2 == in_c2)
                    && (in_c3 == in_c3);
    assign count_eff = clamp_count(count_reg);
    assign unused_zero = ((count_eff > COUNT_W'(1)) || (out_c1 == '0))
                      && ((count_eff > COUNT_W'(2)) || (out_c2 == '0))
                      && ((count_eff > COUNT_W'(3)) || (out_c3 == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg <= 1'b0;
            count_reg   <= COMP_COUNT_RESET;
        end
        else
        begin
            if (in_valid && in_ready && in_seen)
            begin
                seen_in_reg <= 1'b1;
            end
            if (cfg_wr_en && (cfg_index == REG_COMP_COUNT))
            begin
                count_reg <= cfg_wr_data[COUNT_W-1:0];
            end
        end
    end

    `BFMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_c0) && $stable(out_c1) && $stable(out_c2) && $stable(out_c3) && $stable(last_pixel))
    `BFMD_ASSERT_IMPLY(a_no_invented, clk, rst_n, out_valid, seen_in_reg)
    `BFMD_ASSERT_IMPLY(a_unused_zero, clk, rst_n, out_valid, unused_zero)

endmodule

bind box_filter_mip_downsampler_unit bfmd_checker u_bfmd_checker (.*);
